### src/pal_pkg.sv
// Shared types and codes for the positional array list.
// No dependencies; used by pal_seq and positional_array_list.
package pal_pkg;

    localparam int unsigned WORD_W = 32;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_GET     = 3'd2,
        OP_REPLACE = 3'd3,
        OP_FIND    = 3'd4,
        OP_CLEAR   = 3'd5
    } op_t;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_INSERT_ERR = 2'd1;
    localparam logic [1:0] ST_REMOVE_ERR = 2'd2;
    localparam logic [1:0] ST_ACCESS_ERR = 2'd3;

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] read_value;
        logic              found;
        logic [7:0]        count;
        logic              is_empty;
        logic              is_full;
    } res_t;

endpackage

### src/pal_mem.sv
// Entry store: simple dual-port RAM, one write and one registered read per cycle.
// Depends on pal_pkg for the word width.
module pal_mem #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [pal_pkg::WORD_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [pal_pkg::WORD_W-1:0] rdata
);

    logic [pal_pkg::WORD_W-1:0] store_mem [DEPTH];
    logic [pal_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
        rdata_reg <= store_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/pal_seq.sv
// Sequencer for the list: bounds checks, entry count, and the shift / search
// walk over the entry store through one read and one write port.
// Depends on pal_pkg.
module pal_seq #(
    parameter int unsigned CAPACITY = 128,
    parameter int unsigned AW       = 7,
    parameter int unsigned CW       = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [2:0]                 op_in,
    input  logic [7:0]                 pos_in,
    input  logic [pal_pkg::WORD_W-1:0] val_in,
    input  logic                       out_free,
    output logic                       idle,
    output logic                       done,
    output pal_pkg::res_t              res,
    output logic [AW-1:0]              mem_raddr,
    input  logic [pal_pkg::WORD_W-1:0] mem_rdata,
    output logic                       mem_we,
    output logic [AW-1:0]              mem_waddr,
    output logic [pal_pkg::WORD_W-1:0] mem_wdata
);

    localparam int unsigned XW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_GET,
        S_GET_CAP,
        S_FIND,
        S_FIND_LAST,
        S_FIN
    } state_t;

    state_t                     state_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              idx_reg;
    logic [CW-1:0]              end_reg;
    logic [CW-1:0]              wa_reg;
    logic [AW-1:0]              pos_reg;
    logic [pal_pkg::WORD_W-1:0] val_reg;
    logic                       pend_reg;
    logic                       up_reg;
    logic [1:0]                 status_reg;
    logic [pal_pkg::WORD_W-1:0] rd_reg;
    logic                       hit_reg;

    logic [XW-1:0] posx;
    logic [XW-1:0] cntx;
    logic [CW-1:0] pos_cw;
    logic          hit_now;

    assign posx    = XW'(pos_in);
    assign cntx    = XW'(count_reg);
    assign pos_cw  = posx[CW-1:0];
    assign hit_now = pend_reg && (mem_rdata == val_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        pos_reg    <= pos_cw[AW-1:0];
                        val_reg    <= val_in;
                        rd_reg     <= '0;
                        hit_reg    <= 1'b0;
                        pend_reg   <= 1'b0;
                        unique case (op_in)
                            pal_pkg::OP_INSERT: begin
                                if (count_reg != CAP_CW && posx <= cntx) begin
                                    count_reg  <= count_reg + 1'b1;
                                    status_reg <= pal_pkg::ST_OK;
                                    if (posx == cntx) begin
                                        state_reg <= S_PUT;
                                    end else begin
                                        // move entries pos..n-1 up, top first
                                        idx_reg   <= count_reg - 1'b1;
                                        end_reg   <= pos_cw;
                                        up_reg    <= 1'b1;
                                        state_reg <= S_SHIFT;
                                    end
                                end else begin
                                    status_reg <= pal_pkg::ST_INSERT_ERR;
                                    state_reg  <= S_FIN;
                                end
                            end
                            pal_pkg::OP_REMOVE: begin
                                if (posx < cntx) begin
                                    count_reg  <= count_reg - 1'b1;
                                    status_reg <= pal_pkg::ST_OK;
                                    if (posx + 1'b1 != cntx) begin
                                        idx_reg   <= pos_cw + 1'b1;
                                        end_reg   <= count_reg - 1'b1;
                                        up_reg    <= 1'b0;
                                        state_reg <= S_SHIFT;
                                    end else begin
                                        state_reg <= S_FIN;
                                    end
                                end else begin
                                    status_reg <= pal_pkg::ST_REMOVE_ERR;
                                    state_reg  <= S_FIN;
                                end
                            end
                            pal_pkg::OP_GET: begin
                                if (posx < cntx) begin
                                    idx_reg    <= pos_cw;
                                    status_reg <= pal_pkg::ST_OK;
                                    state_reg  <= S_GET;
                                end else begin
                                    status_reg <= pal_pkg::ST_ACCESS_ERR;
                                    state_reg  <= S_FIN;
                                end
                            end
                            pal_pkg::OP_REPLACE: begin
                                if (posx < cntx) begin
                                    status_reg <= pal_pkg::ST_OK;
                                    state_reg  <= S_PUT;
                                end else begin
                                    status_reg <= pal_pkg::ST_ACCESS_ERR;
                                    state_reg  <= S_FIN;
                                end
                            end
                            pal_pkg::OP_FIND: begin
                                status_reg <= pal_pkg::ST_OK;
                                if (count_reg != '0) begin
                                    idx_reg   <= '0;
                                    end_reg   <= count_reg - 1'b1;
                                    state_reg <= S_FIND;
                                end else begin
                                    state_reg <= S_FIN;
                                end
                            end
                            pal_pkg::OP_CLEAR: begin
                                count_reg  <= '0;
                                status_reg <= pal_pkg::ST_OK;
                                state_reg  <= S_FIN;
                            end
                            default: begin
                                status_reg <= pal_pkg::ST_OK;
                                state_reg  <= S_FIN;
                            end
                        endcase
                    end
                end
                S_SHIFT: begin
                    // write lands in the cycle after its read (registered RAM output)
                    pend_reg <= 1'b1;
                    wa_reg   <= up_reg ? idx_reg + 1'b1 : idx_reg - 1'b1;
                    if (idx_reg == end_reg) begin
                        state_reg <= S_DRAIN;
                    end else begin
                        idx_reg <= up_reg ? idx_reg - 1'b1 : idx_reg + 1'b1;
                    end
                end
                S_DRAIN: begin
                    pend_reg  <= 1'b0;
                    state_reg <= up_reg ? S_PUT : S_FIN;
                end
                S_PUT: begin
                    state_reg <= S_FIN;
                end
                S_GET: begin
                    state_reg <= S_GET_CAP;
                end
                S_GET_CAP: begin
                    rd_reg    <= mem_rdata;
                    state_reg <= S_FIN;
                end
                S_FIND: begin
                    pend_reg <= 1'b1;
                    hit_reg  <= hit_reg | hit_now;
                    if (idx_reg == end_reg) begin
                        state_reg <= S_FIND_LAST;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_FIND_LAST: begin
                    pend_reg  <= 1'b0;
                    hit_reg   <= hit_reg | hit_now;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        mem_raddr = idx_reg[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = wa_reg[AW-1:0];
        mem_wdata = mem_rdata;
        unique case (state_reg)
            S_SHIFT: begin
                mem_we = pend_reg;
            end
            S_DRAIN: begin
                mem_we = 1'b1;
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                mem_wdata = val_reg;
            end
            default: begin
            end
        endcase
    end

    logic [XW-1:0] cnt_ext;
    assign cnt_ext = XW'(count_reg);

    assign idle           = (state_reg == S_IDLE);
    assign done           = (state_reg == S_FIN) && out_free;
    assign res.status     = status_reg;
    assign res.read_value = rd_reg;
    assign res.found      = hit_reg;
    assign res.count      = cnt_ext[7:0];
    assign res.is_empty   = (count_reg == '0);
    assign res.is_full    = (count_reg == CAP_CW);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CW)
        else $error("entry count above capacity");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_FIND || state_reg == S_FIN) |-> !mem_we)
        else $error("store written outside a write step");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT || state_reg == S_FIND) |-> idx_reg < CAP_CW)
        else $error("walk index beyond store");

    a_start_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && idle) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start");

    a_fin_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && !out_free) |=> (state_reg == S_FIN))
        else $error("result dropped while output busy");
`endif

endmodule

### src/positional_array_list.sv
// Positional array list: bounded ordered list of signed 32-bit words.
// Insert, remove and find may walk the entries one per cycle through the
// single-port-pair entry store; clear, get, replace and refused requests
// touch at most one entry.
// One item at a time; s_ready is high only while the sequencer is idle.
// Reset (aresetn, synchronous, active low) empties the list; store contents stay.
module positional_array_list #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_opcode,
    input  logic [7:0]         s_position,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_read_value,
    output logic               m_found,
    output logic [7:0]         m_count,
    output logic               m_is_empty,
    output logic               m_is_full
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic                       start;
    logic                       idle;
    logic                       done;
    logic                       out_free;
    pal_pkg::res_t              res;
    pal_pkg::res_t              res_reg;
    logic                       m_valid_reg;
    logic [AW-1:0]              mem_raddr;
    logic [AW-1:0]              mem_waddr;
    logic                       mem_we;
    logic [pal_pkg::WORD_W-1:0] mem_rdata;
    logic [pal_pkg::WORD_W-1:0] mem_wdata;

    assign s_ready  = idle;
    assign start    = s_valid && idle;
    assign out_free = !m_valid_reg || m_ready;

    pal_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .op_in     (s_opcode),
        .pos_in    (s_position),
        .val_in    (s_value),
        .out_free  (out_free),
        .idle      (idle),
        .done      (done),
        .res       (res),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

    pal_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // result register: holds the item until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            res_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = res_reg.status;
    assign m_read_value = res_reg.read_value;
    assign m_found      = res_reg.found;
    assign m_count      = res_reg.count;
    assign m_is_empty   = res_reg.is_empty;
    assign m_is_full    = res_reg.is_full;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench for positional_array_list: directed table, then random rounds checked
// against an in-bench model of the list. Depends on pal_pkg and the RTL top.
module tb;

    localparam int CAP = 128;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ROUND_ITEMS = 200;

    // opcodes the block ignores
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    // slots: insert, remove, get, replace, find, clear, spare
    localparam logic [2:0] OP_BY_SLOT [7] = '{pal_pkg::OP_INSERT, pal_pkg::OP_REMOVE,
                                             pal_pkg::OP_GET, pal_pkg::OP_REPLACE,
                                             pal_pkg::OP_FIND, pal_pkg::OP_CLEAR,
                                             OP_SPARE6};
    localparam int OP_WEIGHTS [3][7] = '{'{78, 4, 6, 4, 5, 0, 3},
                                        '{10, 65, 8, 7, 7, 1, 2},
                                        '{30, 25, 15, 10, 12, 3, 5}};
    localparam int ROUND_MODES [4] = '{MODE_FILL, MODE_DRAIN, MODE_FILL, MODE_MIXED};

    typedef struct packed {
        logic [2:0]    op;
        logic [7:0]    pos;
        logic [31:0]   val;
        logic          typed;
        pal_pkg::res_t want;
    } list_req_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_opcode;
    logic [7:0]         s_position;
    logic signed [31:0] s_value;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic signed [31:0] m_read_value;
    logic               m_found;
    logic [7:0]         m_count;
    logic               m_is_empty;
    logic               m_is_full;

    positional_array_list #(.CAPACITY(CAP)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_position(s_position), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_read_value(m_read_value), .m_found(m_found), .m_count(m_count),
        .m_is_empty(m_is_empty), .m_is_full(m_is_full)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    logic [31:0]   list_words [CAP];
    int unsigned   list_len;
    list_req_t     directed_rows [$];
    list_req_t     offered_reqs [$];
    pal_pkg::res_t pending_results [$];
    int            mismatches = 0;
    int            cycle_count = 0;
    int            stall_left = 0;
    bit            steady = 1'b0;

    // Updates the list copy for one request and returns the result it gives.
    function automatic pal_pkg::res_t step_list(input logic [2:0] op, input logic [7:0] pos,
                                                input logic [31:0] val);
        pal_pkg::res_t r;
        int i;
        r = '0;
        r.status = pal_pkg::ST_OK;
        case (op)
            pal_pkg::OP_INSERT: begin
                if (list_len < CAP && pos <= list_len) begin
                    for (i = list_len; i > pos; i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = val;
                    list_len++;
                end else
                    r.status = pal_pkg::ST_INSERT_ERR;
            end
            pal_pkg::OP_REMOVE: begin
                if (pos < list_len) begin
                    for (i = pos + 1; i < list_len; i++)
                        list_words[i-1] = list_words[i];
                    list_len--;
                end else
                    r.status = pal_pkg::ST_REMOVE_ERR;
            end
            pal_pkg::OP_GET: begin
                if (pos < list_len)
                    r.read_value = list_words[pos];
                else
                    r.status = pal_pkg::ST_ACCESS_ERR;
            end
            pal_pkg::OP_REPLACE: begin
                if (pos < list_len)
                    list_words[pos] = val;
                else
                    r.status = pal_pkg::ST_ACCESS_ERR;
            end
            pal_pkg::OP_FIND: begin
                for (i = 0; i < list_len; i++)
                    if (list_words[i] == val)
                        r.found = 1'b1;
            end
            pal_pkg::OP_CLEAR: list_len = 0;
            default: ;
        endcase
        r.count    = list_len[7:0];
        r.is_empty = (list_len == 0);
        r.is_full  = (list_len == CAP);
        return r;
    endfunction

    task automatic add_row(input logic [2:0] op, input logic [7:0] pos, input logic [31:0] val,
                           input logic typed, input logic [1:0] st, input logic [7:0] cnt);
        list_req_t row;
        row = '0;
        row.op = op;
        row.pos = pos;
        row.val = val;
        row.typed = typed;
        row.want.status = st;
        row.want.count = cnt;
        row.want.is_empty = (cnt == 0);
        row.want.is_full = (cnt == CAP);
        directed_rows.push_back(row);
    endtask

    // mostly short gaps, now and then a long one; none in steady stretches
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic make_request(input int mode, output list_req_t req);
        int r, k, acc, hi, len_now;
        req = '0;
        len_now = list_len;
        r = $urandom_range(0, 99);
        acc = 0;
        req.op = OP_SPARE6;
        for (k = 0; k < 7; k++) begin
            acc += OP_WEIGHTS[mode][k];
            if (r < acc) begin
                req.op = OP_BY_SLOT[k];
                break;
            end
        end
        if (req.op == OP_SPARE6 && $urandom_range(0, 1))
            req.op = OP_SPARE7;
        hi = (req.op == pal_pkg::OP_INSERT) ? len_now : ((len_now > 0) ? len_now - 1 : 0);
        r = $urandom_range(0, 9);
        if (r < 6)
            req.pos = 8'($urandom_range(0, hi));
        else if (r == 6)
            req.pos = 8'(len_now);
        else if (r == 7)
            req.pos = 0;
        else
            req.pos = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 9);
        if (req.op == pal_pkg::OP_FIND && len_now > 0 && r < 5)
            req.val = list_words[$urandom_range(0, len_now - 1)];
        else if (r < 7)
            req.val = $urandom;
        else begin
            case ($urandom_range(0, 3))
                0: req.val = 32'h8000_0000;
                1: req.val = 32'h7fff_ffff;
                2: req.val = 32'hffff_ffff;
                default: req.val = $urandom_range(0, 3);
            endcase
        end
    endtask

    task automatic offer_request(input list_req_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        offered_reqs.push_back(req);
        s_valid    <= 1'b1;
        s_opcode   <= req.op;
        s_position <= req.pos;
        s_value    <= req.val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic compare_result(input pal_pkg::res_t want, input pal_pkg::res_t got);
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
        if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d",
                   $signed(want.read_value), $signed(got.read_value));
            mismatches++;
        end
        if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            mismatches++;
        end
        if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            mismatches++;
        end
        if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
            mismatches++;
        end
        if (got.is_full !== want.is_full) begin
            $error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
            mismatches++;
        end
    endtask

    // handshakes are judged on the values present just before the edge
    always @(posedge aclk) begin : monitor
        list_req_t req;
        pal_pkg::res_t want, got;
        if (aresetn) begin
            if (s_valid && s_ready && offered_reqs.size() > 0) begin
                req = offered_reqs.pop_front();
                want = step_list(req.op, req.pos, req.val);
                if (req.typed)
                    want = req.want;
                pending_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                got.status     = m_status;
                got.read_value = m_read_value;
                got.found      = m_found;
                got.count      = m_count;
                got.is_empty   = m_is_empty;
                got.is_full    = m_is_full;
                if (pending_results.size() == 0) begin
                    $error("result item with nothing pending, status %0d count %0d",
                           m_status, m_count);
                    mismatches++;
                end else
                    compare_result(pending_results.pop_front(), got);
            end
        end
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 5) == 0) begin
            stall_left <= pick_gap();
            m_ready <= 1'b0;
        end else
            m_ready <= 1'b1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        list_req_t req;
        int k, rnd, n;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_opcode   = '0;
        s_position = '0;
        s_value    = '0;
        list_len   = 0;
        for (k = 0; k < CAP; k++)
            list_words[k] = '0;

        // op, pos, value, typed, status, count
        add_row(pal_pkg::OP_GET,     0,   32'h0,         1, pal_pkg::ST_ACCESS_ERR, 0);
        add_row(pal_pkg::OP_REMOVE,  0,   32'h0,         1, pal_pkg::ST_REMOVE_ERR, 0);
        add_row(pal_pkg::OP_REPLACE, 0,   32'h1,         1, pal_pkg::ST_ACCESS_ERR, 0);
        add_row(pal_pkg::OP_INSERT,  1,   32'h1,         1, pal_pkg::ST_INSERT_ERR, 0);
        add_row(pal_pkg::OP_FIND,    0,   32'h0,         1, pal_pkg::ST_OK,         0);
        add_row(OP_SPARE6,           0,   32'h0,         1, pal_pkg::ST_OK,         0);
        add_row(OP_SPARE7,           255, 32'hffff_ffff, 1, pal_pkg::ST_OK,         0);
        add_row(pal_pkg::OP_CLEAR,   0,   32'h0,         1, pal_pkg::ST_OK,         0);
        add_row(pal_pkg::OP_INSERT,  0,   32'h8000_0000, 1, pal_pkg::ST_OK,         1);
        add_row(pal_pkg::OP_INSERT,  1,   32'h7fff_ffff, 1, pal_pkg::ST_OK,         2);  // append
        add_row(pal_pkg::OP_INSERT,  0,   32'hffff_ffff, 1, pal_pkg::ST_OK,         3);
        add_row(pal_pkg::OP_GET,     2,   32'h0,         0, pal_pkg::ST_OK,         0);
        add_row(pal_pkg::OP_GET,     3,   32'h0,         1, pal_pkg::ST_ACCESS_ERR, 3);
        add_row(pal_pkg::OP_GET,     255, 32'h0,         1, pal_pkg::ST_ACCESS_ERR, 3);
        add_row(pal_pkg::OP_REPLACE, 1,   32'h0,         0, pal_pkg::ST_OK,         0);
        add_row(pal_pkg::OP_FIND,    0,   32'h8000_0000, 0, pal_pkg::ST_OK,         0);
        add_row(pal_pkg::OP_FIND,    0,   32'h5555_aaaa, 0, pal_pkg::ST_OK,         0);
        add_row(pal_pkg::OP_FIND,    0,   32'h0,         0, pal_pkg::ST_OK,         0);
        add_row(pal_pkg::OP_REMOVE,  3,   32'h0,         1, pal_pkg::ST_REMOVE_ERR, 3);
        add_row(pal_pkg::OP_REMOVE,  2,   32'h0,         0, pal_pkg::ST_OK,         0);
        add_row(pal_pkg::OP_REMOVE,  0,   32'h0,         0, pal_pkg::ST_OK,         0);
        add_row(pal_pkg::OP_INSERT,  128, 32'h2,         1, pal_pkg::ST_INSERT_ERR, 1);
        add_row(pal_pkg::OP_INSERT,  2,   32'h2,         1, pal_pkg::ST_INSERT_ERR, 1);
        add_row(pal_pkg::OP_CLEAR,   0,   32'h0,         1, pal_pkg::ST_OK,         0);
        add_row(pal_pkg::OP_REMOVE,  0,   32'h0,         1, pal_pkg::ST_REMOVE_ERR, 0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[k])
            offer_request(directed_rows[k]);

        // fill rounds run into the full list; drain rounds empty it again
        for (rnd = 0; rnd < 4; rnd++) begin
            for (n = 0; n < ROUND_ITEMS; n++) begin
                if (n % 50 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                make_request(ROUND_MODES[rnd], req);
                offer_request(req);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (CAP + 8) @(posedge aclk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
